[rtl/core/ugpb_pkg.sv]
// ----------------------------------------------------------------------------
// ugpb_pkg
// Shared types and constants of the uniform grid point binning unit.
// ----------------------------------------------------------------------------
package ugpb_pkg;

   // field widths of the request and response words
   localparam int OP_W        = 2;
   localparam int COORD_W     = 24;
   localparam int IDX_OUT_W   = 12;
   localparam int TOTAL_W     = 11;
   localparam int SLOT_W      = 10;
   localparam int FRAC_W      = 16;

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // parameter defaults
   localparam int CELLS_PER_AXIS_DEF = 16;
   localparam int MAX_POINTS_DEF     = 1024;

   // operation codes
   localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
   localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // register indexes (paddr bit 2)
   localparam logic REG_GRID_MIN   = 1'b0;
   localparam logic REG_CELL_SCALE = 1'b1;

   localparam logic signed [COORD_W-1:0] GRID_MIN_RST   = -24'sd2048;
   localparam logic        [COORD_W-1:0] CELL_SCALE_RST = 24'd256;

   // empty bounding box
   localparam logic signed [COORD_W-1:0] BOX_POS = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] BOX_NEG = 24'sh800000;

   typedef struct packed {
      logic signed [COORD_W-1:0] grid_min;
      logic        [COORD_W-1:0] cell_scale;
   } cfg_type;

endpackage

[rtl/core/ugpb_ram.sv]
// ----------------------------------------------------------------------------
// ugpb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ugpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ugpb_csr.sv]
// ----------------------------------------------------------------------------
// ugpb_csr
// APB-style register file: grid lower corner and Q16 cell scale.
// ----------------------------------------------------------------------------
module ugpb_csr import ugpb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   logic    wr_go;

   assign pready = 1'b1;
   assign wr_go  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_min   <= GRID_MIN_RST;
         cfg_ff.cell_scale <= CELL_SCALE_RST;
      end else if (wr_go) begin
         case (paddr[2])
            REG_GRID_MIN:   cfg_ff.grid_min   <= pwdata[COORD_W-1:0];
            REG_CELL_SCALE: cfg_ff.cell_scale <= pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_GRID_MIN:   prdata = CSR_DATA_W'(unsigned'(cfg_ff.grid_min));
         REG_CELL_SCALE: prdata = CSR_DATA_W'(cfg_ff.cell_scale);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/ugpb_quant.sv]
// ----------------------------------------------------------------------------
// ugpb_quant
// Three-lane axis quantiser: offset, Q16 scale multiply (registered), then
// range check and linear cell index.
// ----------------------------------------------------------------------------
module ugpb_quant import ugpb_pkg::*; #(
   parameter int CELLS_PER_AXIS = CELLS_PER_AXIS_DEF,
   localparam int IdxW = $clog2(CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS)
) (
   input  logic                      clock,
   input  cfg_type                   cfg,
   input  logic signed [COORD_W-1:0] coord_x,
   input  logic signed [COORD_W-1:0] coord_y,
   input  logic signed [COORD_W-1:0] coord_z,
   output logic                      hit,
   output logic [IdxW-1:0]           cell_index
);

   localparam int QW   = $clog2(CELLS_PER_AXIS);
   localparam int PW   = 2 * COORD_W;
   localparam int CW   = PW - FRAC_W;
   localparam logic [IdxW-1:0] STRIDE_Y = IdxW'(CELLS_PER_AXIS);
   localparam logic [IdxW-1:0] STRIDE_Z = IdxW'(CELLS_PER_AXIS * CELLS_PER_AXIS);

   logic signed [COORD_W-1:0] coord   [3];
   logic signed [COORD_W:0]   diff    [3];
   logic [PW-1:0]             prod_in [3];
   logic [PW-1:0]             prod_ff [3];
   logic                      neg_ff  [3];
   logic [CW-1:0]             quo     [3];
   logic                      axis_ok [3];
   logic [QW-1:0]             q       [3];

   assign coord[0] = coord_x;
   assign coord[1] = coord_y;
   assign coord[2] = coord_z;

   // stage 1: non-negative offsets fit in 24 bits unsigned
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]    = {coord[i][COORD_W-1], coord[i]}
                    - {cfg.grid_min[COORD_W-1], cfg.grid_min};
         prod_in[i] = PW'(diff[i][COORD_W-1:0]) * PW'(cfg.cell_scale);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
         neg_ff[i]  <= diff[i][COORD_W];
      end
   end

   // stage 2: floor by dropping the fraction, then range check
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo[i]     = prod_ff[i][PW-1:FRAC_W];
         axis_ok[i] = !neg_ff[i] && (quo[i] < CW'(CELLS_PER_AXIS));
         q[i]       = quo[i][QW-1:0];
      end
   end

   assign hit        = axis_ok[0] && axis_ok[1] && axis_ok[2];
   assign cell_index = IdxW'(q[0]) + IdxW'(q[1]) * STRIDE_Y + IdxW'(q[2]) * STRIDE_Z;

endmodule

[rtl/core/uniform_grid_point_binning_unit.sv]
// ----------------------------------------------------------------------------
// uniform_grid_point_binning_unit
// Bins 3-D points into a cubic uniform grid with per-cell counters in RAM.
// ----------------------------------------------------------------------------
// Each request word carries an operation and a point. The point is quantised
// per axis as floor((coord - grid_min) * cell_scale / 2^16); points with any
// axis outside 0..CELLS_PER_AXIS-1 leave all tables untouched. A count word
// bumps the cell's counter, a place word hands out the point's slot in its
// cell and a running point number and grows the bounding box of placed
// points; a clear word empties every table. All counters saturate at
// MAX_POINTS. A point passes through the accept cycle, in which the
// multipliers run, and the cycle in which the cell RAM is read; the
// write-back cycle overlaps the acceptance of the next word. The cell RAM's
// single read port and its registered read output set that order. After
// reset and after every clear word a sweep zeroes the RAM one cell per cycle,
// over CELLS_PER_AXIS^3 cells (4096 by default), with req_stall high;
// configuration writes are taken throughout. A response waits in an output
// register, so the next word may be accepted while it is still stalled.
// Configuration must only change while the unit is idle.
// ----------------------------------------------------------------------------
module uniform_grid_point_binning_unit import ugpb_pkg::*; #(
   parameter int CELLS_PER_AXIS = CELLS_PER_AXIS_DEF,
   parameter int MAX_POINTS     = MAX_POINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_in_grid,
   output logic [IDX_OUT_W-1:0]      rsp_cell_index,
   output logic [TOTAL_W-1:0]        rsp_cell_total,
   output logic [SLOT_W-1:0]         rsp_slot_in_cell,
   output logic [SLOT_W-1:0]         rsp_point_number,
   output logic signed [COORD_W-1:0] rsp_box_min_x,
   output logic signed [COORD_W-1:0] rsp_box_min_y,
   output logic signed [COORD_W-1:0] rsp_box_min_z,
   output logic signed [COORD_W-1:0] rsp_box_max_x,
   output logic signed [COORD_W-1:0] rsp_box_max_y,
   output logic signed [COORD_W-1:0] rsp_box_max_z,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int NCELLS = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
   localparam int IdxW   = $clog2(NCELLS);
   localparam int CntW   = $clog2(MAX_POINTS + 1);
   localparam int EntW   = 2 * CntW;      // {fill, count}
   localparam logic [IdxW-1:0] LAST_CELL = IdxW'(NCELLS - 1);
   localparam logic [CntW-1:0] CNT_MAX   = CntW'(MAX_POINTS);
   localparam logic [CntW-1:0] SLOT_MAX  = CntW'(MAX_POINTS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_WRITE
   } state_type;

   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
   endfunction

   function automatic logic [CntW-1:0] clamp_slot(input logic [CntW-1:0] v);
      return (v < CNT_MAX) ? v : SLOT_MAX;
   endfunction

   cfg_type cfg;

   // ---------------------------------------------------------------- control
   state_type                 state_ff;
   logic [IdxW-1:0]           sweep_ff;
   logic [OP_W-1:0]           op_ff;
   logic signed [COORD_W-1:0] coord_ff [3];
   logic                      hit_ff;
   logic [IdxW-1:0]           idx_ff;
   logic [CntW-1:0]           placed_ff;
   logic signed [COORD_W-1:0] low_ff   [3];
   logic signed [COORD_W-1:0] high_ff  [3];

   // ------------------------------------------------------- response register
   logic                      rsp_valid_ff;
   logic                      rsp_in_grid_ff;
   logic [IDX_OUT_W-1:0]      rsp_index_ff;
   logic [TOTAL_W-1:0]        rsp_total_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic [SLOT_W-1:0]         rsp_pnum_ff;
   logic signed [COORD_W-1:0] rsp_low_ff  [3];
   logic signed [COORD_W-1:0] rsp_high_ff [3];

   // ------------------------------------------------------------ datapath
   logic                      q_hit;
   logic [IdxW-1:0]           q_index;
   logic                      out_free;
   logic                      wr_go;
   logic                      take;
   logic                      is_clear;
   logic                      place_hit;

   logic                      ram_wr_en;
   logic [IdxW-1:0]           ram_wr_addr;
   logic [EntW-1:0]           ram_wr_data;
   logic [EntW-1:0]           ram_rd_data;

   logic [CntW-1:0]           cnt_old;
   logic [CntW-1:0]           fill_old;
   logic [CntW-1:0]           cnt_inc;
   logic [CntW-1:0]           fill_inc;
   logic [CntW-1:0]           placed_in;
   logic [EntW-1:0]           entry_in;
   logic [CntW-1:0]           total_in;
   logic [CntW-1:0]           slot_in;
   logic [CntW-1:0]           pnum_in;
   logic signed [COORD_W-1:0] low_in   [3];
   logic signed [COORD_W-1:0] high_in  [3];

   ugpb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // products are registered on the accept edge; hit/index valid in S_READ
   ugpb_quant #(
      .CELLS_PER_AXIS (CELLS_PER_AXIS)
   ) u_quant (
      .clock      (clock),
      .cfg        (cfg),
      .coord_x    (req_coord_x),
      .coord_y    (req_coord_y),
      .coord_z    (req_coord_z),
      .hit        (q_hit),
      .cell_index (q_index)
   );

   ugpb_ram #(
      .WIDTH (EntW),
      .DEPTH (NCELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == S_READ),
      .rd_addr (q_index),
      .rd_data (ram_rd_data)
   );

   // handshake: a new word may enter alongside the write-back, except after
   // a clear, which hands over to the sweep
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_clear  = (op_ff == OP_CLEAR);
   assign wr_go     = (state_ff == S_WRITE) && out_free;
   assign req_stall = !((state_ff == S_IDLE) || (wr_go && !is_clear));
   assign take      = req_valid && !req_stall;
   assign place_hit = hit_ff && (op_ff == OP_PLACE);

   // read-modify-write of the cell entry; the next read of any cell happens
   // in S_READ, after this write has landed, so no forwarding is needed
   assign cnt_old  = ram_rd_data[CntW-1:0];
   assign fill_old = ram_rd_data[EntW-1:CntW];

   always_comb begin
      cnt_inc   = sat_inc(cnt_old);
      fill_inc  = sat_inc(fill_old);
      placed_in = place_hit ? sat_inc(placed_ff) : placed_ff;
      entry_in  = (op_ff == OP_COUNT) ? {fill_old, cnt_inc} : {fill_inc, cnt_old};
      total_in  = '0;
      slot_in   = '0;
      pnum_in   = '0;
      if (hit_ff) begin
         total_in = (op_ff == OP_COUNT) ? cnt_inc : cnt_old;
         if (op_ff == OP_PLACE) begin
            slot_in = clamp_slot(fill_old);
            pnum_in = clamp_slot(placed_ff);
         end
      end
      for (int i = 0; i < 3; i++) begin
         low_in[i]  = (place_hit && (coord_ff[i] < low_ff[i]))  ? coord_ff[i] : low_ff[i];
         high_in[i] = (place_hit && (coord_ff[i] > high_ff[i])) ? coord_ff[i] : high_ff[i];
      end
   end

   assign ram_wr_en   = (state_ff == S_CLEAR) || (wr_go && hit_ff);
   assign ram_wr_addr = (state_ff == S_CLEAR) ? sweep_ff : idx_ff;
   assign ram_wr_data = (state_ff == S_CLEAR) ? '0 : entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         placed_ff    <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            low_ff[i]  <= BOX_POS;
            high_ff[i] <= BOX_NEG;
         end
      end else begin
         // new word on write-back, else the held one leaves when taken
         if (wr_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            op_ff       <= req_operation;
            coord_ff[0] <= req_coord_x;
            coord_ff[1] <= req_coord_y;
            coord_ff[2] <= req_coord_z;
         end
         case (state_ff)
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == LAST_CELL) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (take) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               hit_ff   <= q_hit && ((op_ff == OP_COUNT) || (op_ff == OP_PLACE));
               idx_ff   <= q_index;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (out_free) begin
                  rsp_in_grid_ff <= hit_ff;
                  rsp_index_ff   <= hit_ff ? IDX_OUT_W'(idx_ff) : '0;
                  rsp_total_ff   <= TOTAL_W'(total_in);
                  rsp_slot_ff    <= SLOT_W'(slot_in);
                  rsp_pnum_ff    <= SLOT_W'(pnum_in);
                  if (is_clear) begin
                     state_ff  <= S_CLEAR;
                     sweep_ff  <= '0;
                     placed_ff <= '0;
                     for (int i = 0; i < 3; i++) begin
                        low_ff[i]      <= BOX_POS;
                        high_ff[i]     <= BOX_NEG;
                        rsp_low_ff[i]  <= BOX_POS;
                        rsp_high_ff[i] <= BOX_NEG;
                     end
                  end else begin
                     placed_ff <= placed_in;
                     for (int i = 0; i < 3; i++) begin
                        low_ff[i]      <= low_in[i];
                        high_ff[i]     <= high_in[i];
                        rsp_low_ff[i]  <= low_in[i];
                        rsp_high_ff[i] <= high_in[i];
                     end
                     state_ff <= take ? S_READ : S_IDLE;
                  end
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_in_grid      = rsp_in_grid_ff;
   assign rsp_cell_index   = rsp_index_ff;
   assign rsp_cell_total   = rsp_total_ff;
   assign rsp_slot_in_cell = rsp_slot_ff;
   assign rsp_point_number = rsp_pnum_ff;
   assign rsp_box_min_x    = rsp_low_ff[0];
   assign rsp_box_min_y    = rsp_low_ff[1];
   assign rsp_box_min_z    = rsp_low_ff[2];
   assign rsp_box_max_x    = rsp_high_ff[0];
   assign rsp_box_max_y    = rsp_high_ff[1];
   assign rsp_box_max_z    = rsp_high_ff[2];

endmodule

[rtl/core/ugpb_checker.sv]
// ----------------------------------------------------------------------------
// ugpb_checker
// Port-level checks of the binning unit, bound to the top level.
// ----------------------------------------------------------------------------
module ugpb_checker import ugpb_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_in_grid,
   input logic [IDX_OUT_W-1:0] rsp_cell_index,
   input logic [TOTAL_W-1:0]   rsp_cell_total,
   input logic [SLOT_W-1:0]    rsp_slot_in_cell,
   input logic [SLOT_W-1:0]    rsp_point_number
);

   // a stalled response word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cell_index) && $stable(rsp_cell_total))
      else $error("stalled response word changed");

   // outside the grid every cell field reads zero
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_grid |-> rsp_cell_index == '0 && rsp_cell_total == '0
                                    && rsp_slot_in_cell == '0 && rsp_point_number == '0)
      else $error("cell fields set for a point outside the grid");

   // the RAM read cycle follows every accepted word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word accepted while the previous one is still reading");

   // the clearing sweep follows reset: no response right away
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word after reset");

endmodule

bind uniform_grid_point_binning_unit ugpb_checker u_ugpb_checker (.*);
